FILE: rtl/dual_pwm_capture_measure_defines.svh
// Assertion macros for the dual PWM capture measurement block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef DUAL_PWM_CAPTURE_MEASURE_DEFINES_SVH
`define DUAL_PWM_CAPTURE_MEASURE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DPCM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DPCM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dpcm_pkg.sv
// Shared types and constants for the dual PWM capture measurement block.
// No dependencies.
`default_nettype none

package dpcm_pkg;

  // Field widths fixed by the interface.
  localparam int CAP_W    = 16;
  localparam int WRAP_W   = 7;
  localparam int TICKS_W  = 23;
  localparam int FREQ_W   = 16;
  localparam int ERR_W    = 16;
  localparam int RATE_W   = 27;
  localparam int SCALE_W  = 8;
  localparam int CFG_IDX_W = 2;

  // Divider geometry: rate * scale over period ticks, at most 17 quotient bits kept.
  localparam int NUM_W   = RATE_W + SCALE_W;
  localparam int DEN_W   = TICKS_W;
  localparam int Q_W     = FREQ_W + 1;
  localparam int HI_W    = NUM_W - Q_W;
  localparam int CNT_W   = $clog2(Q_W + 1);

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  // Register indexes on the config port.
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT = 2'd3;

  // Reset values of the config registers.
  localparam logic [RATE_W-1:0]  RST_TICK_RATE  = 27'd9000000;
  localparam logic [SCALE_W-1:0] RST_FREQ_SCALE = 8'd5;
  localparam logic [FREQ_W-1:0]  RST_MAX_FREQ   = 16'd10000;
  localparam logic [WRAP_W-1:0]  RST_WRAP_LIMIT = 7'd100;

  typedef enum logic [1:0] {
    OUTCOME_PUBLISHED = 2'd0,
    OUTCOME_MISSED    = 2'd1,
    OUTCOME_RANGE     = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_RESULT
  } state_t;

  // Status returned by the serial divider.
  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
    logic           rem_nz;
  } div_res_t;

endpackage

`default_nettype wire

FILE: rtl/dpcm_ext.sv
// Wrap extension of one channel's captures into period and pulse ticks.
// Depends on dpcm_pkg.
`default_nettype none

module dpcm_ext #(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic [dpcm_pkg::WRAP_W-1:0]  wraps,
  input  wire logic [dpcm_pkg::CAP_W-1:0]   last_edge,
  input  wire logic [dpcm_pkg::CAP_W-1:0]   pcap,
  input  wire logic [dpcm_pkg::CAP_W-1:0]   wcap,
  output logic      [dpcm_pkg::TICKS_W-1:0] period_ticks,
  output logic      [dpcm_pkg::TICKS_W-1:0] pulse_ticks
);

  // One sign bit plus headroom; never narrower than the tick fields.
  localparam int MAG_W = (COUNTER_BITS + dpcm_pkg::WRAP_W > dpcm_pkg::TICKS_W - 2) ?
                         COUNTER_BITS + dpcm_pkg::WRAP_W : dpcm_pkg::TICKS_W - 2;
  localparam int EW = MAG_W + 2;

  logic [dpcm_pkg::WRAP_W-1:0] wraps_pul;
  logic [EW-1:0] span_one;
  logic [EW-1:0] per_raw;
  logic [EW-1:0] pul_raw;
  logic [EW-1:0] per_fix;
  logic [EW-1:0] pul_fix;

  assign span_one  = EW'(1) << COUNTER_BITS;
  // pulse edge before period edge: one wrap fewer
  assign wraps_pul = (pcap < wcap && wraps != '0) ? wraps - 1'b1 : wraps;

  assign per_raw = (EW'(wraps) << COUNTER_BITS) + EW'(pcap) - EW'(last_edge);
  assign pul_raw = (EW'(wraps_pul) << COUNTER_BITS) + EW'(wcap) - EW'(last_edge);

  assign per_fix = per_raw[EW-1] ? per_raw + span_one : per_raw;
  assign pul_fix = pul_raw[EW-1] ? pul_raw + span_one : pul_raw;

  assign period_ticks = per_fix[dpcm_pkg::TICKS_W-1:0];
  assign pulse_ticks  = pul_fix[dpcm_pkg::TICKS_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/dpcm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on dpcm_pkg. Caller guarantees dividend high part < divisor.
`default_nettype none

module dpcm_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [dpcm_pkg::NUM_W-1:0]   dividend,
  input  wire logic [dpcm_pkg::DEN_W-1:0]   divisor,
  output dpcm_pkg::div_res_t                res
);

  logic [dpcm_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [dpcm_pkg::Q_W-1:0]   quo_r, quo_nxt;
  logic [dpcm_pkg::DEN_W-1:0] den_r;
  logic [dpcm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [dpcm_pkg::DEN_W:0]   trial;
  logic [dpcm_pkg::DEN_W:0]   diff;

  assign trial = {rem_r, quo_r[dpcm_pkg::Q_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dpcm_pkg::DEN_W'(dividend[dpcm_pkg::NUM_W-1:dpcm_pkg::Q_W]);
      quo_nxt  = dividend[dpcm_pkg::Q_W-1:0];
      cnt_nxt  = dpcm_pkg::CNT_W'(dpcm_pkg::Q_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[dpcm_pkg::DEN_W]) begin
        rem_nxt = diff[dpcm_pkg::DEN_W-1:0];
        quo_nxt = {quo_r[dpcm_pkg::Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[dpcm_pkg::DEN_W-1:0];
        quo_nxt = {quo_r[dpcm_pkg::Q_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dpcm_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign res.done   = done_r;
  assign res.quo    = quo_r;
  assign res.rem_nz = |rem_r;

endmodule

`default_nettype wire

FILE: rtl/dual_pwm_capture_measure.sv
// Top level of the dual PWM capture measurement block.
// Depends on dpcm_pkg, dpcm_ext, dpcm_div and the assertion macro header.
`default_nettype none

`include "dual_pwm_capture_measure_defines.svh"

// Takes one timer event word per handshake and returns one result word for
// each channel that captured (A before B, last set on the final one). Wrap
// counts are bumped and limit-checked at the moment the event is taken.
// Each captured channel then runs through the same datapath: the calc state
// extends the captures into period and pulse ticks, and a bit-serial
// divider forms tick_rate_hz * frequency_scale / period, one quotient bit
// per cycle. A measured channel passes through the calc, divide and result
// states (the divide state covers the divider load, its steps and the done
// flag); a missed edge or an obviously out-of-range period skips the
// divider and goes from the calc state straight to the result state.
// The block works on one event at a time; in_ready is high only while it is
// idle. Results sit in an output register, so a new event is taken while
// the last result still waits for out_ready. Config writes are taken every
// cycle and are meant to happen only while the block is idle.
module dual_pwm_capture_measure #(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,

  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dpcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dpcm_pkg::RATE_W-1:0]      cfg_data,

  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_counter_wrapped,
  input  wire logic                             in_missed_edge,
  input  wire logic                             in_event_a,
  input  wire logic [dpcm_pkg::CAP_W-1:0]       in_period_capture_a,
  input  wire logic [dpcm_pkg::CAP_W-1:0]       in_width_capture_a,
  input  wire logic                             in_event_b,
  input  wire logic [dpcm_pkg::CAP_W-1:0]       in_period_capture_b,
  input  wire logic [dpcm_pkg::CAP_W-1:0]       in_width_capture_b,

  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_channel,
  output logic      [1:0]                       out_outcome,
  output logic      [dpcm_pkg::TICKS_W-1:0]     out_period_ticks,
  output logic      [dpcm_pkg::TICKS_W-1:0]     out_pulse_ticks,
  output logic      [dpcm_pkg::FREQ_W-1:0]      out_frequency,
  output logic      [dpcm_pkg::ERR_W-1:0]       out_error_total,
  output logic                                  out_last
);

  // ---------------------------------------------------------------- config
  logic [dpcm_pkg::RATE_W-1:0]  tick_rate_r;
  logic [dpcm_pkg::SCALE_W-1:0] freq_scale_r;
  logic [dpcm_pkg::FREQ_W-1:0]  max_freq_r;
  logic [dpcm_pkg::WRAP_W-1:0]  wrap_limit_r;
  logic [dpcm_pkg::NUM_W-1:0]   num_r;  // tick rate * scale, refreshed every cycle

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r  <= dpcm_pkg::RST_TICK_RATE;
      freq_scale_r <= dpcm_pkg::RST_FREQ_SCALE;
      max_freq_r   <= dpcm_pkg::RST_MAX_FREQ;
      wrap_limit_r <= dpcm_pkg::RST_WRAP_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dpcm_pkg::CFG_TICK_RATE:  tick_rate_r  <= cfg_data;
        dpcm_pkg::CFG_FREQ_SCALE: freq_scale_r <= cfg_data[dpcm_pkg::SCALE_W-1:0];
        dpcm_pkg::CFG_MAX_FREQ:   max_freq_r   <= cfg_data[dpcm_pkg::FREQ_W-1:0];
        dpcm_pkg::CFG_WRAP_LIMIT: wrap_limit_r <= cfg_data[dpcm_pkg::WRAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    num_r <= dpcm_pkg::NUM_W'(tick_rate_r) * dpcm_pkg::NUM_W'(freq_scale_r);
  end

  // ------------------------------------------------------------ event latch
  logic                          item_missed_r;
  logic                          item_ev_b_r;
  logic [dpcm_pkg::CAP_W-1:0]    item_pa_r, item_wa_r, item_pb_r, item_wb_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_missed_r <= in_missed_edge;
      item_ev_b_r   <= in_event_b;
      item_pa_r     <= in_period_capture_a;
      item_wa_r     <= in_width_capture_a;
      item_pb_r     <= in_period_capture_b;
      item_wb_r     <= in_width_capture_b;
    end
  end

  // ------------------------------------------------------- state registers
  dpcm_pkg::state_t              state_r, state_nxt;
  logic                          ch_r, ch_nxt;          // 0 = A, 1 = B
  logic [dpcm_pkg::WRAP_W-1:0]   wraps_a_r, wraps_a_nxt;
  logic [dpcm_pkg::WRAP_W-1:0]   wraps_b_r, wraps_b_nxt;
  logic [dpcm_pkg::CAP_W-1:0]    edge_a_r, edge_a_nxt;
  logic [dpcm_pkg::CAP_W-1:0]    edge_b_r, edge_b_nxt;
  logic [dpcm_pkg::ERR_W-1:0]    err_r, err_nxt;
  logic [dpcm_pkg::TICKS_W-1:0]  pt_r, pt_nxt;
  logic [dpcm_pkg::TICKS_W-1:0]  wt_r, wt_nxt;
  dpcm_pkg::outcome_t            outcome_r, outcome_nxt;
  logic [dpcm_pkg::FREQ_W-1:0]   freq_r, freq_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_channel_r, out_channel_nxt;
  dpcm_pkg::outcome_t            out_outcome_r, out_outcome_nxt;
  logic [dpcm_pkg::TICKS_W-1:0]  out_period_r, out_period_nxt;
  logic [dpcm_pkg::TICKS_W-1:0]  out_pulse_r, out_pulse_nxt;
  logic [dpcm_pkg::FREQ_W-1:0]   out_freq_r, out_freq_nxt;
  logic [dpcm_pkg::ERR_W-1:0]    out_err_r, out_err_nxt;
  logic                          out_last_r, out_last_nxt;

  // --------------------------------------------------- wrap count update
  // Both counts bump on a wrap; if either passes the limit both clear.
  logic [dpcm_pkg::WRAP_W:0]     wa_inc, wb_inc;
  logic                          wrap_clr;

  assign wa_inc   = {1'b0, wraps_a_r} + {{dpcm_pkg::WRAP_W{1'b0}}, in_counter_wrapped};
  assign wb_inc   = {1'b0, wraps_b_r} + {{dpcm_pkg::WRAP_W{1'b0}}, in_counter_wrapped};
  assign wrap_clr = (wa_inc > {1'b0, wrap_limit_r}) || (wb_inc > {1'b0, wrap_limit_r});

  // ------------------------------------------------------ channel datapath
  logic [dpcm_pkg::WRAP_W-1:0]   cur_wraps;
  logic [dpcm_pkg::CAP_W-1:0]    cur_edge, cur_pcap, cur_wcap;
  logic [dpcm_pkg::TICKS_W-1:0]  ext_period, ext_pulse;
  logic                          div_start;
  dpcm_pkg::div_res_t            div_res;
  logic                          num_too_big;

  assign cur_wraps = ch_r ? wraps_b_r : wraps_a_r;
  assign cur_edge  = ch_r ? edge_b_r  : edge_a_r;
  assign cur_pcap  = ch_r ? item_pb_r : item_pa_r;
  assign cur_wcap  = ch_r ? item_wb_r : item_wa_r;

  dpcm_ext #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_ext (
    .wraps        (cur_wraps),
    .last_edge    (cur_edge),
    .pcap         (cur_pcap),
    .wcap         (cur_wcap),
    .period_ticks (ext_period),
    .pulse_ticks  (ext_pulse)
  );

  // Quotient would need more than 17 bits (also true for a zero period):
  // certainly above any max_frequency, so the divider is skipped.
  assign num_too_big =
    dpcm_pkg::DEN_W'(num_r[dpcm_pkg::NUM_W-1:dpcm_pkg::Q_W]) >= ext_period;

  dpcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (ext_period),
    .res      (div_res)
  );

  // --------------------------------------------------------------- control
  always_comb begin
    state_nxt       = state_r;
    ch_nxt          = ch_r;
    wraps_a_nxt     = wraps_a_r;
    wraps_b_nxt     = wraps_b_r;
    edge_a_nxt      = edge_a_r;
    edge_b_nxt      = edge_b_r;
    err_nxt         = err_r;
    pt_nxt          = pt_r;
    wt_nxt          = wt_r;
    outcome_nxt     = outcome_r;
    freq_nxt        = freq_r;
    div_start       = 1'b0;
    in_ready        = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_channel_nxt = out_channel_r;
    out_outcome_nxt = out_outcome_r;
    out_period_nxt  = out_period_r;
    out_pulse_nxt   = out_pulse_r;
    out_freq_nxt    = out_freq_r;
    out_err_nxt     = out_err_r;
    out_last_nxt    = out_last_r;

    case (state_r)
      dpcm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          wraps_a_nxt = wrap_clr ? '0 : wa_inc[dpcm_pkg::WRAP_W-1:0];
          wraps_b_nxt = wrap_clr ? '0 : wb_inc[dpcm_pkg::WRAP_W-1:0];
          if (in_event_a) begin
            ch_nxt    = 1'b0;
            state_nxt = dpcm_pkg::ST_CALC;
          end else if (in_event_b) begin
            ch_nxt    = 1'b1;
            state_nxt = dpcm_pkg::ST_CALC;
          end
        end
      end

      dpcm_pkg::ST_CALC: begin
        pt_nxt   = ext_period;
        wt_nxt   = ext_pulse;
        freq_nxt = '0;
        if (ch_r) begin
          edge_b_nxt  = item_pb_r;
          wraps_b_nxt = '0;
        end else begin
          edge_a_nxt  = item_pa_r;
          wraps_a_nxt = '0;
        end
        if (item_missed_r) begin
          if (err_r != dpcm_pkg::ERR_MAX) begin
            err_nxt = err_r + 1'b1;
          end
          outcome_nxt = dpcm_pkg::OUTCOME_MISSED;
          state_nxt   = dpcm_pkg::ST_RESULT;
        end else if (num_too_big) begin
          outcome_nxt = dpcm_pkg::OUTCOME_RANGE;
          state_nxt   = dpcm_pkg::ST_RESULT;
        end else begin
          div_start = 1'b1;
          state_nxt = dpcm_pkg::ST_DIV;
        end
      end

      dpcm_pkg::ST_DIV: begin
        if (div_res.done) begin
          // exact check: num > max * period  <=>  q > max, or q == max with remainder
          if (div_res.quo > dpcm_pkg::Q_W'(max_freq_r) ||
              (div_res.quo == dpcm_pkg::Q_W'(max_freq_r) && div_res.rem_nz)) begin
            outcome_nxt = dpcm_pkg::OUTCOME_RANGE;
          end else begin
            outcome_nxt = dpcm_pkg::OUTCOME_PUBLISHED;
            freq_nxt    = div_res.quo[dpcm_pkg::FREQ_W-1:0];
          end
          state_nxt = dpcm_pkg::ST_RESULT;
        end
      end

      dpcm_pkg::ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_channel_nxt = ch_r;
          out_outcome_nxt = outcome_r;
          out_period_nxt  = pt_r;
          out_pulse_nxt   = wt_r;
          out_freq_nxt    = freq_r;
          out_err_nxt     = err_r;
          out_last_nxt    = ch_r || !item_ev_b_r;
          if (!ch_r && item_ev_b_r) begin
            ch_nxt    = 1'b1;
            state_nxt = dpcm_pkg::ST_CALC;
          end else begin
            state_nxt = dpcm_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = dpcm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpcm_pkg::ST_IDLE;
      ch_r        <= 1'b0;
      wraps_a_r   <= '0;
      wraps_b_r   <= '0;
      edge_a_r    <= '0;
      edge_b_r    <= '0;
      err_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      wraps_a_r   <= wraps_a_nxt;
      wraps_b_r   <= wraps_b_nxt;
      edge_a_r    <= edge_a_nxt;
      edge_b_r    <= edge_b_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r          <= pt_nxt;
    wt_r          <= wt_nxt;
    outcome_r     <= outcome_nxt;
    freq_r        <= freq_nxt;
    out_channel_r <= out_channel_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_period_r  <= out_period_nxt;
    out_pulse_r   <= out_pulse_nxt;
    out_freq_r    <= out_freq_nxt;
    out_err_r     <= out_err_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_outcome      = out_outcome_r;
  assign out_period_ticks = out_period_r;
  assign out_pulse_ticks  = out_pulse_r;
  assign out_frequency    = out_freq_r;
  assign out_error_total  = out_err_r;
  assign out_last         = out_last_r;

  // ------------------------------------------------------------ assertions
  // A published frequency never exceeds the configured ceiling.
  `DPCM_ASSERT_NOW(a_pub_in_range,
    out_valid_r && out_outcome_r == dpcm_pkg::OUTCOME_PUBLISHED,
    out_freq_r <= max_freq_r, "published frequency above max_frequency")

  // A missed-edge result always carries a nonzero error total.
  `DPCM_ASSERT_NOW(a_missed_counted,
    out_valid_r && out_outcome_r == dpcm_pkg::OUTCOME_MISSED,
    out_err_r != '0, "missed edge reported without error count")

  // Divider completion only lands while the sequencer waits for it.
  `DPCM_ASSERT_NOW(a_div_done_in_div,
    div_res.done, state_r == dpcm_pkg::ST_DIV, "divider done outside divide state")

  // Handling channel A clears its wrap count.
  `DPCM_ASSERT_NEXT(a_wrap_a_cleared,
    state_r == dpcm_pkg::ST_CALC && !ch_r, wraps_a_r == '0,
    "channel A wrap count not cleared after measurement")

endmodule

`default_nettype wire
